>>> src/thwm_pkg.sv
// Shared constants, types and register codes for the timed history window mean block.
`timescale 1ns / 1ps
package thwm_pkg;

    localparam int HISTORY_DEPTH = 160;
    localparam int VALUE_BITS    = 16;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W         = VALUE_BITS + CNT_W;
    localparam int STEP_W        = $clog2(SUM_W);
    localparam int TIME_W        = 32;
    localparam int OFS_W         = 16;
    localparam int FIELD_W       = 16;
    localparam int MEAN_W        = 16;
    localparam int COUNT_W       = 8;
    localparam int NUM_MEANS     = 5;
    localparam int MIDX_W        = 3;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam logic [OFS_W-1:0] RST_BAL_FAR  = 16'd300;
    localparam logic [OFS_W-1:0] RST_BAL_NEAR = 16'd100;
    localparam logic [OFS_W-1:0] RST_HGT_FAR  = 16'd130;
    localparam logic [OFS_W-1:0] RST_HGT_NEAR = 16'd30;

    typedef enum logic [1:0] {
        REG_BAL_FAR  = 2'd0,
        REG_BAL_NEAR = 2'd1,
        REG_HGT_FAR  = 2'd2,
        REG_HGT_NEAR = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [TIME_W-1:0]     time_ms;
        logic [VALUE_BITS-1:0] lf;
        logic [VALUE_BITS-1:0] rf;
        logic [VALUE_BITS-1:0] lr;
        logic [VALUE_BITS-1:0] rr;
        logic [VALUE_BITS-1:0] thrust;
    } item_t;

    typedef struct packed {
        logic [OFS_W-1:0] bal_far;
        logic [OFS_W-1:0] bal_near;
        logic [OFS_W-1:0] hgt_far;
        logic [OFS_W-1:0] hgt_near;
    } cfg_t;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_lf;
        logic [MEAN_W-1:0]  mean_rf;
        logic [MEAN_W-1:0]  mean_lr;
        logic [MEAN_W-1:0]  mean_rr;
        logic [MEAN_W-1:0]  mean_thrust;
        logic [COUNT_W-1:0] balance_count;
        logic [COUNT_W-1:0] height_count;
    } result_t;

endpackage

>>> src/thwm_front.sv
// Input side: a two-entry transaction queue that classifies items as push or query.
`timescale 1ns / 1ps
module thwm_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           mode,
    input  logic [thwm_pkg::TIME_W-1:0]    time_ms,
    input  logic [thwm_pkg::FIELD_W-1:0]   throttle_lf,
    input  logic [thwm_pkg::FIELD_W-1:0]   throttle_rf,
    input  logic [thwm_pkg::FIELD_W-1:0]   throttle_lr,
    input  logic [thwm_pkg::FIELD_W-1:0]   throttle_rr,
    input  logic [thwm_pkg::FIELD_W-1:0]   thrust_value,
    output logic                           item_valid,
    output thwm_pkg::item_t                item,
    input  logic                           item_take
);

    thwm_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            wr_en;
    logic            rd_en;
    thwm_pkg::item_t new_item;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    always_comb
    begin
        new_item.op      = mode ? thwm_pkg::OP_QUERY : thwm_pkg::OP_PUSH;
        new_item.time_ms = time_ms;
        new_item.lf      = thwm_pkg::VALUE_BITS'(throttle_lf);
        new_item.rf      = thwm_pkg::VALUE_BITS'(throttle_rf);
        new_item.lr      = thwm_pkg::VALUE_BITS'(throttle_lr);
        new_item.rr      = thwm_pkg::VALUE_BITS'(throttle_rr);
        new_item.thrust  = thwm_pkg::VALUE_BITS'(thrust_value);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> src/thwm_back.sv
// Execution side: history memory, window scan, shared divider and result register.
`timescale 1ns / 1ps
module thwm_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  thwm_pkg::cfg_t    cfg,
    input  logic              item_valid,
    input  thwm_pkg::item_t   item,
    output logic              item_take,
    output logic              res_full,
    output thwm_pkg::result_t res,
    input  logic              res_pop
);

    localparam int VB = thwm_pkg::VALUE_BITS;
    localparam int D  = thwm_pkg::HISTORY_DEPTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_OUT
    } state_t;

    // History memories
    logic [thwm_pkg::TIME_W-1:0] stamp_mem  [D];
    logic [4*VB-1:0]             thr_mem    [D];
    logic [VB-1:0]               thrust_mem [D];
    logic [D-1:0]                valid_reg;

    logic [thwm_pkg::TIME_W-1:0] stamp_rd_reg;
    logic [4*VB-1:0]             thr_rd_reg;
    logic [VB-1:0]               thrust_rd_reg;
    logic                        vld_rd_reg;

    state_t                          state_reg,   state_next;
    logic [thwm_pkg::PTR_W-1:0]      wp_reg,      wp_next;
    logic [thwm_pkg::PTR_W-1:0]      raddr_reg,   raddr_next;
    logic [thwm_pkg::CNT_W-1:0]      issued_reg,  issued_next;
    logic                            pend_reg,    pend_next;
    logic                            bdone_reg,   bdone_next;
    logic                            hdone_reg,   hdone_next;
    logic [thwm_pkg::TIME_W-1:0]     bfar_reg,    bfar_next;
    logic [thwm_pkg::TIME_W-1:0]     bnear_reg,   bnear_next;
    logic [thwm_pkg::TIME_W-1:0]     hfar_reg,    hfar_next;
    logic [thwm_pkg::TIME_W-1:0]     hnear_reg,   hnear_next;
    logic [thwm_pkg::CNT_W-1:0]      bcnt_reg,    bcnt_next;
    logic [thwm_pkg::CNT_W-1:0]      hcnt_reg,    hcnt_next;
    logic [thwm_pkg::SUM_W-1:0]      sum_reg  [thwm_pkg::NUM_MEANS];
    logic [thwm_pkg::SUM_W-1:0]      sum_next [thwm_pkg::NUM_MEANS];
    logic [thwm_pkg::MEAN_W-1:0]     mean_reg [thwm_pkg::NUM_MEANS];
    logic [thwm_pkg::MEAN_W-1:0]     mean_next[thwm_pkg::NUM_MEANS];
    logic [thwm_pkg::MIDX_W-1:0]     didx_reg,    didx_next;
    logic [thwm_pkg::STEP_W-1:0]     step_reg,    step_next;
    logic [thwm_pkg::CNT_W:0]        rem_reg,     rem_next;
    logic [thwm_pkg::SUM_W-1:0]      quo_reg,     quo_next;
    logic                            rfull_reg,   rfull_next;
    thwm_pkg::result_t               res_reg,     res_next;

    logic                        wr_en;
    logic                        rd_en;
    logic                        b_take, b_stop, h_take, h_stop;
    logic [thwm_pkg::CNT_W-1:0]  div_cnt;
    logic [thwm_pkg::CNT_W:0]    trial;
    logic                        qbit;
    logic [thwm_pkg::SUM_W-1:0]  quo_step;
    logic [31:0]                 bcnt32, hcnt32;

    assign res_full = rfull_reg;
    assign res      = res_reg;
    assign wr_en    = (state_reg == S_IDLE) && item_valid && (item.op == thwm_pkg::OP_PUSH);
    assign rd_en    = (state_reg == S_SCAN) && (issued_reg != thwm_pkg::CNT_W'(D));
    assign item_take = (state_reg == S_IDLE) && item_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[wp_reg]  <= item.time_ms;
            thr_mem[wp_reg]    <= {item.rr, item.lr, item.rf, item.lf};
            thrust_mem[wp_reg] <= item.thrust;
        end
        if (rd_en)
        begin
            stamp_rd_reg  <= stamp_mem[raddr_reg];
            thr_rd_reg    <= thr_mem[raddr_reg];
            thrust_rd_reg <= thrust_mem[raddr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wp_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_rd_reg <= valid_reg[raddr_reg];
            end
        end
    end

    // Window classification of the entry that has just been read.
    always_comb
    begin
        b_take = vld_rd_reg && (stamp_rd_reg <= bnear_reg) && (stamp_rd_reg >= bfar_reg);
        b_stop = !vld_rd_reg || ((stamp_rd_reg <= bnear_reg) && (stamp_rd_reg < bfar_reg));
        h_take = vld_rd_reg && (stamp_rd_reg <= hnear_reg) && (stamp_rd_reg >= hfar_reg);
        h_stop = !vld_rd_reg || ((stamp_rd_reg <= hnear_reg) && (stamp_rd_reg < hfar_reg));
    end

    // One restoring division step.
    always_comb
    begin
        div_cnt  = (didx_reg == thwm_pkg::MIDX_W'(thwm_pkg::NUM_MEANS - 1)) ? hcnt_reg : bcnt_reg;
        trial    = {rem_reg[thwm_pkg::CNT_W-1:0], quo_reg[thwm_pkg::SUM_W-1]};
        qbit     = (trial >= {1'b0, div_cnt});
        quo_step = {quo_reg[thwm_pkg::SUM_W-2:0], qbit};
        bcnt32   = 32'(bcnt_reg);
        hcnt32   = 32'(hcnt_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        raddr_next  = raddr_reg;
        issued_next = issued_reg;
        pend_next   = 1'b0;
        bdone_next  = bdone_reg;
        hdone_next  = hdone_reg;
        bfar_next   = bfar_reg;
        bnear_next  = bnear_reg;
        hfar_next   = hfar_reg;
        hnear_next  = hnear_reg;
        bcnt_next   = bcnt_reg;
        hcnt_next   = hcnt_reg;
        sum_next    = sum_reg;
        mean_next   = mean_reg;
        didx_next   = didx_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        rfull_next  = rfull_reg;
        res_next    = res_reg;

        if (res_pop && rfull_reg)
        begin
            rfull_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.op == thwm_pkg::OP_PUSH)
                    begin
                        wp_next = (wp_reg == thwm_pkg::PTR_W'(D - 1)) ? '0 : wp_reg + 1'b1;
                    end
                    else
                    begin
                        bfar_next   = item.time_ms - thwm_pkg::TIME_W'(cfg.bal_far);
                        bnear_next  = item.time_ms - thwm_pkg::TIME_W'(cfg.bal_near);
                        hfar_next   = item.time_ms - thwm_pkg::TIME_W'(cfg.hgt_far);
                        hnear_next  = item.time_ms - thwm_pkg::TIME_W'(cfg.hgt_near);
                        raddr_next  = (wp_reg == '0) ? thwm_pkg::PTR_W'(D - 1) : wp_reg - 1'b1;
                        issued_next = '0;
                        bdone_next  = 1'b0;
                        hdone_next  = 1'b0;
                        bcnt_next   = '0;
                        hcnt_next   = '0;
                        for (int k = 0; k < thwm_pkg::NUM_MEANS; k++)
                        begin
                            sum_next[k] = '0;
                        end
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_en)
                begin
                    pend_next   = 1'b1;
                    issued_next = issued_reg + 1'b1;
                    raddr_next  = (raddr_reg == '0) ? thwm_pkg::PTR_W'(D - 1) : raddr_reg - 1'b1;
                end
                if (pend_reg)
                begin
                    if (!bdone_reg)
                    begin
                        if (b_take)
                        begin
                            bcnt_next   = bcnt_reg + 1'b1;
                            sum_next[0] = sum_reg[0] + thwm_pkg::SUM_W'(thr_rd_reg[0*VB +: VB]);
                            sum_next[1] = sum_reg[1] + thwm_pkg::SUM_W'(thr_rd_reg[1*VB +: VB]);
                            sum_next[2] = sum_reg[2] + thwm_pkg::SUM_W'(thr_rd_reg[2*VB +: VB]);
                            sum_next[3] = sum_reg[3] + thwm_pkg::SUM_W'(thr_rd_reg[3*VB +: VB]);
                        end
                        bdone_next = b_stop;
                    end
                    if (!hdone_reg)
                    begin
                        if (h_take)
                        begin
                            hcnt_next   = hcnt_reg + 1'b1;
                            sum_next[4] = sum_reg[4] + thwm_pkg::SUM_W'(thrust_rd_reg);
                        end
                        hdone_next = h_stop;
                    end
                end
                if ((bdone_next && hdone_next) || (!rd_en && !pend_reg))
                begin
                    pend_next  = 1'b0;
                    didx_next  = '0;
                    step_next  = '0;
                    rem_next   = '0;
                    quo_next   = sum_next[0];
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next  = qbit ? (trial - {1'b0, div_cnt}) : trial;
                quo_next  = quo_step;
                step_next = step_reg + 1'b1;
                if (step_reg == thwm_pkg::STEP_W'(thwm_pkg::SUM_W - 1))
                begin
                    mean_next[didx_reg] = (div_cnt == '0) ? '0 : thwm_pkg::MEAN_W'(quo_step);
                    if (didx_reg == thwm_pkg::MIDX_W'(thwm_pkg::NUM_MEANS - 1))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        didx_next = didx_reg + 1'b1;
                        step_next = '0;
                        rem_next  = '0;
                        quo_next  = sum_reg[didx_reg + 1'b1];
                    end
                end
            end

            S_OUT:
            begin
                if (!rfull_reg)
                begin
                    res_next.mean_lf       = mean_reg[0];
                    res_next.mean_rf       = mean_reg[1];
                    res_next.mean_lr       = mean_reg[2];
                    res_next.mean_rr       = mean_reg[3];
                    res_next.mean_thrust   = mean_reg[4];
                    res_next.balance_count = (bcnt32 > 32'd255) ? 8'hFF : bcnt32[7:0];
                    res_next.height_count  = (hcnt32 > 32'd255) ? 8'hFF : hcnt32[7:0];
                    rfull_next             = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            pend_reg  <= 1'b0;
            rfull_reg <= 1'b0;
            bdone_reg <= 1'b0;
            hdone_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            pend_reg   <= pend_next;
            rfull_reg  <= rfull_next;
            bdone_reg  <= bdone_next;
            hdone_reg  <= hdone_next;
            raddr_reg  <= raddr_next;
            issued_reg <= issued_next;
            bfar_reg   <= bfar_next;
            bnear_reg  <= bnear_next;
            hfar_reg   <= hfar_next;
            hnear_reg  <= hnear_next;
            bcnt_reg   <= bcnt_next;
            hcnt_reg   <= hcnt_next;
            sum_reg    <= sum_next;
            mean_reg   <= mean_next;
            didx_reg   <= didx_next;
            step_reg   <= step_next;
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
            res_reg    <= res_next;
        end
    end

endmodule

>>> src/timed_history_window_mean.sv
// Top level of the timed history window mean block: register port, front queue and engine.
//
//   Channel   Handshake                      Payload
//   input     push / full                    mode, time_ms, four throttles, thrust_value
//   result    empty / pop                    four throttle means, mean_thrust, two counts
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata (four 16-bit offsets)
//
// A push transaction is stored first in the front queue and then written to the history
// memory. A query transaction reads the history memory once per cycle, newest first, for
// up to 160 entries, and then runs five restoring divisions of 24 steps each on a shared
// divider. Reset clears the valid bits, the write pointer and all handshake state at once;
// there is no clearing pass. While a result waits unpopped, the engine still takes push
// transactions.
`timescale 1ns / 1ps
module timed_history_window_mean
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                mode,
    input  logic [thwm_pkg::TIME_W-1:0]         time_ms,
    input  logic [thwm_pkg::FIELD_W-1:0]        throttle_lf,
    input  logic [thwm_pkg::FIELD_W-1:0]        throttle_rf,
    input  logic [thwm_pkg::FIELD_W-1:0]        throttle_lr,
    input  logic [thwm_pkg::FIELD_W-1:0]        throttle_rr,
    input  logic [thwm_pkg::FIELD_W-1:0]        thrust_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [thwm_pkg::MEAN_W-1:0]         mean_lf,
    output logic [thwm_pkg::MEAN_W-1:0]         mean_rf,
    output logic [thwm_pkg::MEAN_W-1:0]         mean_lr,
    output logic [thwm_pkg::MEAN_W-1:0]         mean_rr,
    output logic [thwm_pkg::MEAN_W-1:0]         mean_thrust,
    output logic [thwm_pkg::COUNT_W-1:0]        balance_count,
    output logic [thwm_pkg::COUNT_W-1:0]        height_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [thwm_pkg::ADDR_W-1:0]         paddr,
    input  logic [thwm_pkg::DATA_W-1:0]         pwdata,
    output logic [thwm_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    thwm_pkg::cfg_t     cfg_reg;
    thwm_pkg::item_t    item;
    thwm_pkg::result_t  res;
    thwm_pkg::reg_idx_t reg_sel;
    logic               item_valid;
    logic               item_take;
    logic               res_full;
    logic               cfg_wr;

    // The register index comes from the word address; the byte offset within a word is ignored.
    assign reg_sel = thwm_pkg::reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bal_far  <= thwm_pkg::RST_BAL_FAR;
            cfg_reg.bal_near <= thwm_pkg::RST_BAL_NEAR;
            cfg_reg.hgt_far  <= thwm_pkg::RST_HGT_FAR;
            cfg_reg.hgt_near <= thwm_pkg::RST_HGT_NEAR;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                thwm_pkg::REG_BAL_FAR:  cfg_reg.bal_far  <= pwdata[thwm_pkg::OFS_W-1:0];
                thwm_pkg::REG_BAL_NEAR: cfg_reg.bal_near <= pwdata[thwm_pkg::OFS_W-1:0];
                thwm_pkg::REG_HGT_FAR:  cfg_reg.hgt_far  <= pwdata[thwm_pkg::OFS_W-1:0];
                thwm_pkg::REG_HGT_NEAR: cfg_reg.hgt_near <= pwdata[thwm_pkg::OFS_W-1:0];
                default:                cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // Read-back of the offsets, zero-extended to the bus width.
    always_comb
    begin
        case (reg_sel)
            thwm_pkg::REG_BAL_FAR:  prdata = thwm_pkg::DATA_W'(cfg_reg.bal_far);
            thwm_pkg::REG_BAL_NEAR: prdata = thwm_pkg::DATA_W'(cfg_reg.bal_near);
            thwm_pkg::REG_HGT_FAR:  prdata = thwm_pkg::DATA_W'(cfg_reg.hgt_far);
            thwm_pkg::REG_HGT_NEAR: prdata = thwm_pkg::DATA_W'(cfg_reg.hgt_near);
            default:                prdata = '0;
        endcase
    end

    // The front queue decouples the producer from the engine's long query scans.
    thwm_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .time_ms      (time_ms),
        .throttle_lf  (throttle_lf),
        .throttle_rf  (throttle_rf),
        .throttle_lr  (throttle_lr),
        .throttle_rr  (throttle_rr),
        .thrust_value (thrust_value),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    // The engine holds the history ring, scans both windows in one pass and divides.
    thwm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_full   (res_full),
        .res        (res),
        .res_pop    (pop)
    );

    assign empty         = !res_full;
    assign mean_lf       = res.mean_lf;
    assign mean_rf       = res.mean_rf;
    assign mean_lr       = res.mean_lr;
    assign mean_rr       = res.mean_rr;
    assign mean_thrust   = res.mean_thrust;
    assign balance_count = res.balance_count;
    assign height_count  = res.height_count;

endmodule

>>> src/thwm_checker.sv
// Port-level checks for the timed history window mean block, bound to its top level.
`timescale 1ns / 1ps
module thwm_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic                          pready,
    input logic [thwm_pkg::MEAN_W-1:0]   mean_lf,
    input logic [thwm_pkg::MEAN_W-1:0]   mean_rf,
    input logic [thwm_pkg::MEAN_W-1:0]   mean_lr,
    input logic [thwm_pkg::MEAN_W-1:0]   mean_rr,
    input logic [thwm_pkg::MEAN_W-1:0]   mean_thrust,
    input logic [thwm_pkg::COUNT_W-1:0]  balance_count,
    input logic [thwm_pkg::COUNT_W-1:0]  height_count
);

    // An empty balance window yields zero means.
    a_bal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && balance_count == '0) |->
            (mean_lf == '0 && mean_rf == '0 && mean_lr == '0 && mean_rr == '0))
        else $error("balance means not zero for an empty window");

    // An empty height window yields a zero thrust mean.
    a_hgt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && height_count == '0) |-> (mean_thrust == '0))
        else $error("thrust mean not zero for an empty window");

    // No window can count more records than the history holds.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(balance_count) <= 32'(thwm_pkg::HISTORY_DEPTH) &&
                    32'(height_count) <= 32'(thwm_pkg::HISTORY_DEPTH)))
        else $error("window count exceeds history depth");

    // A result that is not popped stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(mean_lf) && $stable(mean_thrust) &&
                              $stable(balance_count) && $stable(height_count)))
        else $error("waiting result changed or vanished");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind timed_history_window_mean thwm_checker u_thwm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .pready        (pready),
    .mean_lf       (mean_lf),
    .mean_rf       (mean_rf),
    .mean_lr       (mean_lr),
    .mean_rr       (mean_rr),
    .mean_thrust   (mean_thrust),
    .balance_count (balance_count),
    .height_count  (height_count)
);

>>> verif/tb.sv
// Self-checking testbench for the timed history window mean block.
`timescale 1ns / 1ps
module tb;
    import thwm_pkg::*;

    // Clock, reset and the block's ports.
    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic mode;
    logic [TIME_W-1:0] time_ms;
    logic [FIELD_W-1:0] throttle_lf;
    logic [FIELD_W-1:0] throttle_rf;
    logic [FIELD_W-1:0] throttle_lr;
    logic [FIELD_W-1:0] throttle_rr;
    logic [FIELD_W-1:0] thrust_value;
    logic empty;
    logic pop;
    logic [MEAN_W-1:0] mean_lf;
    logic [MEAN_W-1:0] mean_rf;
    logic [MEAN_W-1:0] mean_lr;
    logic [MEAN_W-1:0] mean_rr;
    logic [MEAN_W-1:0] mean_thrust;
    logic [COUNT_W-1:0] balance_count;
    logic [COUNT_W-1:0] height_count;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    timed_history_window_mean u_dut
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode),
        .time_ms(time_ms), .throttle_lf(throttle_lf), .throttle_rf(throttle_rf),
        .throttle_lr(throttle_lr), .throttle_rr(throttle_rr),
        .thrust_value(thrust_value), .empty(empty), .pop(pop),
        .mean_lf(mean_lf), .mean_rf(mean_rf), .mean_lr(mean_lr), .mean_rr(mean_rr),
        .mean_thrust(mean_thrust), .balance_count(balance_count),
        .height_count(height_count), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // A query scans up to 160 entries and then divides five times. The watchdog allows well
    // over the worst case of such a query, plus the longest stall of
    // the receiver.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    // The testbench's own copy of the history and of the window offsets.
    logic [TIME_W-1:0]      hist_stamp   [HISTORY_DEPTH];
    logic [VALUE_BITS-1:0]  hist_thr     [HISTORY_DEPTH][4];
    logic [VALUE_BITS-1:0]  hist_thrust  [HISTORY_DEPTH];
    bit                     hist_valid   [HISTORY_DEPTH];
    int                     hist_wr_ptr;
    cfg_t                   offsets;

    // Expected window means, oldest first.
    result_t expected_means[$];

    int  error_count;
    int  idle_cycles;
    bit  stall_enable;
    bit  burst_enable;
    int  queries_sent;
    // Recent push stamp, kept so that the random stimulus builds sensible timelines.
    logic [TIME_W-1:0] clock_ms;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Scans one window newest first and returns its count and its sums.
    function automatic int scan_history(input logic [TIME_W-1:0] now,
                                        input logic [OFS_W-1:0] far_off,
                                        input logic [OFS_W-1:0] near_off,
                                        output longint sums [5]);
        logic [TIME_W-1:0] far_t;
        logic [TIME_W-1:0] near_t;
        int cnt;
        int slot;
        far_t  = now - TIME_W'(far_off);
        near_t = now - TIME_W'(near_off);
        cnt = 0;
        for (int k = 0; k < 5; k++)
            sums[k] = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            slot = (hist_wr_ptr + HISTORY_DEPTH - 1 - i) % HISTORY_DEPTH;
            if (!hist_valid[slot])
                break;
            if (hist_stamp[slot] > near_t)
                continue;
            if (hist_stamp[slot] < far_t)
                break;
            for (int k = 0; k < 4; k++)
                sums[k] += hist_thr[slot][k];
            sums[4] += hist_thrust[slot];
            cnt++;
        end
        return cnt;
    endfunction

    function automatic logic [MEAN_W-1:0] window_mean(input longint sum, input int cnt);
        if (cnt == 0)
            return '0;
        return MEAN_W'(sum / cnt);
    endfunction

    // Updates the history copy for a push, or queues the expected means for a query.
    function automatic void predict_item(input item_t it);
        longint bsum [5];
        longint hsum [5];
        int bcnt;
        int hcnt;
        result_t res;
        if (it.op == OP_PUSH)
        begin
            hist_stamp[hist_wr_ptr]  = it.time_ms;
            hist_thr[hist_wr_ptr][0] = it.lf;
            hist_thr[hist_wr_ptr][1] = it.rf;
            hist_thr[hist_wr_ptr][2] = it.lr;
            hist_thr[hist_wr_ptr][3] = it.rr;
            hist_thrust[hist_wr_ptr] = it.thrust;
            hist_valid[hist_wr_ptr]  = 1'b1;
            hist_wr_ptr = (hist_wr_ptr + 1) % HISTORY_DEPTH;
            return;
        end
        bcnt = scan_history(it.time_ms, offsets.bal_far, offsets.bal_near, bsum);
        hcnt = scan_history(it.time_ms, offsets.hgt_far, offsets.hgt_near, hsum);
        res.mean_lf       = window_mean(bsum[0], bcnt);
        res.mean_rf       = window_mean(bsum[1], bcnt);
        res.mean_lr       = window_mean(bsum[2], bcnt);
        res.mean_rr       = window_mean(bsum[3], bcnt);
        res.mean_thrust   = window_mean(hsum[4], hcnt);
        res.balance_count = COUNT_W'(bcnt > 255 ? 255 : bcnt);
        res.height_count  = COUNT_W'(hcnt > 255 ? 255 : hcnt);
        expected_means.push_back(res);
        queries_sent++;
    endfunction

    // Sends one transaction. Push stays high across back-to-back items, so it is only
    // lowered when a gap follows.
    task automatic send_item(input item_t it);
        push         <= 1'b1;
        mode         <= it.op;
        time_ms      <= it.time_ms;
        throttle_lf  <= it.lf;
        throttle_rf  <= it.rf;
        throttle_lr  <= it.lr;
        throttle_rr  <= it.rr;
        thrust_value <= it.thrust;
        do
            @(posedge clk);
        while (full);
        predict_item(it);
        if (burst_enable && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    task automatic idle_sender();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every expected result has been taken, plus the engine's longest busy
    // time, since a push still in flight gives no result to wait for.
    task automatic wait_drained();
        idle_sender();
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle; pready is always high.
    task automatic write_offset(input reg_idx_t idx, input logic [OFS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BAL_FAR:  offsets.bal_far  = value;
            REG_BAL_NEAR: offsets.bal_near = value;
            REG_HGT_FAR:  offsets.hgt_far  = value;
            REG_HGT_NEAR: offsets.hgt_near = value;
            default:      offsets = offsets;
        endcase
        @(posedge clk);
    endtask

    task automatic set_offsets(input logic [OFS_W-1:0] bf, input logic [OFS_W-1:0] bn,
                               input logic [OFS_W-1:0] hf, input logic [OFS_W-1:0] hn);
        wait_drained();
        write_offset(REG_BAL_FAR, bf);
        write_offset(REG_BAL_NEAR, bn);
        write_offset(REG_HGT_FAR, hf);
        write_offset(REG_HGT_NEAR, hn);
    endtask

    function automatic item_t make_push(input logic [TIME_W-1:0] stamp);
        item_t it;
        it.op      = OP_PUSH;
        it.time_ms = stamp;
        it.lf      = VALUE_BITS'($urandom);
        it.rf      = VALUE_BITS'($urandom);
        it.lr      = VALUE_BITS'($urandom);
        it.rr      = VALUE_BITS'($urandom);
        it.thrust  = VALUE_BITS'($urandom);
        return it;
    endfunction

    // A query carries random throttle bits, which the block must ignore.
    function automatic item_t make_query(input logic [TIME_W-1:0] now);
        item_t it;
        it    = make_push(now);
        it.op = OP_QUERY;
        return it;
    endfunction

    // Directed checks: queries on an empty store, full-scale and zero values, the wrap of
    // the time base and a ring that has wrapped all the way round.
    task automatic test_directed();
        item_t it;
        send_item(make_query(32'd0));
        send_item(make_query(32'hFFFF_FFFF));
        it = make_push(32'd1000);
        it.lf = '1; it.rf = '1; it.lr = '1; it.rr = '1; it.thrust = '1;
        send_item(it);
        it = make_push(32'd1002);
        it.lf = '0; it.rf = '0; it.lr = '0; it.rr = '0; it.thrust = '0;
        send_item(it);
        it = make_push(32'd1100);
        it.lf = '1; it.rf = '1; it.lr = '1; it.rr = '1; it.thrust = '1;
        send_item(it);
        send_item(make_query(32'd1150));
        send_item(make_query(32'd1300));
        send_item(make_query(32'd900));
        send_item(make_query(32'hFFFF_FFF0));
        // Stamps close to the wrap point of the time base.
        send_item(make_push(32'hFFFF_FFFE));
        send_item(make_push(32'h0000_0005));
        send_item(make_query(32'h0000_0040));
        send_item(make_query(32'hFFFF_FFFF));
        // A query with every throttle bit set must still ignore them.
        it = make_query(32'd1200);
        it.lf = '1; it.thrust = '1;
        send_item(it);
        // Fill the whole ring and wrap it once so that every entry is valid.
        for (int i = 0; i < HISTORY_DEPTH + 4; i++)
            send_item(make_push(32'd5000 + 32'(2 * i)));
        send_item(make_query(32'd5000 + 32'(2 * HISTORY_DEPTH)));
        clock_ms = 32'd5000 + 32'(2 * HISTORY_DEPTH);
    endtask

    // Offsets at their extremes: zero-width windows, the full 16-bit span, inverted windows.
    task automatic test_offset_extremes();
        set_offsets(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        send_item(make_query(clock_ms));
        send_item(make_query(clock_ms + 32'd3));
        set_offsets(16'd0, 16'd0, 16'd0, 16'd0);
        send_item(make_query(clock_ms - 32'd2));
        set_offsets(16'd10, 16'd200, 16'd5, 16'hFFFF);
        send_item(make_query(clock_ms));
        send_item(make_query(32'd3));
    endtask

    // Mostly a push stream that advances 0 to 4 ms per item with queries among the pushes,
    // occasionally a jump in time or a fully random stamp.
    task automatic test_random_stream(input int n_items);
        item_t it;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                wait_drained();
            case ($urandom_range(0, 19))
                0: clock_ms = $urandom;
                1: clock_ms = clock_ms + $urandom_range(0, 70000);
                default: clock_ms = clock_ms + $urandom_range(0, 4);
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    it = make_query($urandom);
                else
                    it = make_query(clock_ms + $urandom_range(0, 400));
            end
            else
                it = make_push(clock_ms);
            send_item(it);
        end
    endtask

    // Receiver: pops always, or with stall_enable set stalls at random outside a recurring window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (!stall_enable)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0) || ($time % 1280 < 320);
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_means.size() == 0)
            begin
                $display("%0t: result with nothing expected", $time);
                error_count++;
            end
            else
            begin
                result_t exp_r;
                exp_r = expected_means.pop_front();
                if (mean_lf !== exp_r.mean_lf)
                begin
                    $display("%0t: mean_lf expected %0d actual %0d", $time, exp_r.mean_lf, mean_lf);
                    error_count++;
                end
                if (mean_rf !== exp_r.mean_rf)
                begin
                    $display("%0t: mean_rf expected %0d actual %0d", $time, exp_r.mean_rf, mean_rf);
                    error_count++;
                end
                if (mean_lr !== exp_r.mean_lr)
                begin
                    $display("%0t: mean_lr expected %0d actual %0d", $time, exp_r.mean_lr, mean_lr);
                    error_count++;
                end
                if (mean_rr !== exp_r.mean_rr)
                begin
                    $display("%0t: mean_rr expected %0d actual %0d", $time, exp_r.mean_rr, mean_rr);
                    error_count++;
                end
                if (mean_thrust !== exp_r.mean_thrust)
                begin
                    $display("%0t: mean_thrust expected %0d actual %0d", $time,
                             exp_r.mean_thrust, mean_thrust);
                    error_count++;
                end
                if (balance_count !== exp_r.balance_count)
                begin
                    $display("%0t: balance_count expected %0d actual %0d", $time,
                             exp_r.balance_count, balance_count);
                    error_count++;
                end
                if (height_count !== exp_r.height_count)
                begin
                    $display("%0t: height_count expected %0d actual %0d", $time,
                             exp_r.height_count, height_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction is accepted on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0; mode = 1'b0; time_ms = '0;
        throttle_lf = '0; throttle_rf = '0; throttle_lr = '0; throttle_rr = '0;
        thrust_value = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0; idle_cycles = 0; queries_sent = 0;
        stall_enable = 1'b0; burst_enable = 1'b0;
        hist_wr_ptr = 0; clock_ms = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist_valid[i] = 1'b0;
        offsets.bal_far  = RST_BAL_FAR;
        offsets.bal_near = RST_BAL_NEAR;
        offsets.hgt_far  = RST_HGT_FAR;
        offsets.hgt_near = RST_HGT_NEAR;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_offset_extremes();
        // The reset offsets once more, then random streams under several settings with
        // random idling on both sides.
        set_offsets(RST_BAL_FAR, RST_BAL_NEAR, RST_HGT_FAR, RST_HGT_NEAR);
        test_random_stream(350);
        stall_enable = 1'b1;
        burst_enable = 1'b1;
        test_random_stream(350);
        set_offsets(16'd40, 16'd4, 16'd20, 16'd0);
        test_random_stream(300);
        stall_enable = 1'b0;
        set_offsets(16'($urandom), 16'($urandom_range(0, 300)), 16'($urandom_range(0, 600)),
                    16'($urandom_range(0, 50)));
        test_random_stream(250);

        wait_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> files.f
src/thwm_pkg.sv
src/thwm_front.sv
src/thwm_back.sv
src/timed_history_window_mean.sv
src/thwm_checker.sv
verif/tb.sv
